>>> design/cda_pkg.sv
package cda_pkg;

  // Years are biased by a multiple of 400 so every day count stays positive
  localparam int YearBias  = 400;
  // Day counts are taken from March 1 of this year
  localparam int BaseYear  = 1900;
  localparam int BaseBiased = BaseYear + YearBias;
  // Days before the base year (in March-based years) from biased year zero
  localparam int BaseDays  = BaseBiased * 365 + BaseBiased / 4 - BaseBiased / 100
                             + BaseBiased / 400;

  // Day counts of 1902-01-01 and 2037-12-31 from 1900-03-01
  localparam int CountMin  = 671;
  localparam int CountMax  = 50344;

  // Reciprocals for constant division (estimate low by at most one)
  localparam int Recip100  = 655;    // 2^16 / 100
  localparam int Recip1461 = 45933;  // 2^26 / 1461

  // Day count handed from the forward half to the backward half
  typedef struct packed {
    logic [15:0] z;    // days since 1900-03-01, valid only when err is low
    logic        err;  // result year outside the supported range
  } count_t;

  // First day of a March-based month, 0 is March
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

>>> design/cda_to_count.sv
// Forward half: date plus offset to a day count, three stages
module cda_to_count (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  logic [4:0]            start_day_i,
  input  logic [3:0]            start_month_i,
  input  logic [10:0]           start_year_i,
  input  logic signed [16:0]    day_offset_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output cda_pkg::count_t       cnt_o
);

  // stage valid bits and ready chain
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;

  // stage 1: month wrap, March-based year, month offset, /100 estimate
  logic [3:0]         m_n, mp;
  logic [11:0]        y_car, y_d, y_q;
  logic [8:0]         doy_d, doy_q;
  logic signed [17:0] dsum_d, dsum_q;
  logic [21:0]        p1_d, p1_q;

  always_comb begin
    if (start_month_i == 4'd0) begin
      m_n   = 4'd12;
      y_car = 12'(start_year_i) + 12'(cda_pkg::YearBias) - 12'd1;
    end else if (start_month_i > 4'd12) begin
      m_n   = start_month_i - 4'd12;
      y_car = 12'(start_year_i) + 12'(cda_pkg::YearBias) + 12'd1;
    end else begin
      m_n   = start_month_i;
      y_car = 12'(start_year_i) + 12'(cda_pkg::YearBias);
    end
    if (m_n <= 4'd2) begin
      y_d = y_car - 12'd1;
      mp  = m_n + 4'd9;
    end else begin
      y_d = y_car;
      mp  = m_n - 4'd3;
    end
    doy_d  = cda_pkg::month_start(mp);
    dsum_d = $signed({13'b0, start_day_i}) - 18'sd1 + 18'(day_offset_i);
    p1_d   = 22'(y_d) * 22'(cda_pkg::Recip100);
  end

  // stage 2: exact year/100, linear part of the day count
  logic [5:0]         q_est, q_d, q_q;
  logic [11:0]        rem100;
  logic signed [21:0] ylong;
  logic signed [21:0] part_d, part_q;

  always_comb begin
    q_est  = p1_q[21:16];
    rem100 = y_q - 12'(q_est) * 12'd100;
    q_d    = (rem100 >= 12'd100) ? q_est + 6'd1 : q_est;
    ylong  = $signed({10'b0, y_q});
    part_d = ylong * 22'sd365 + (ylong >>> 2) + $signed({13'b0, doy_q})
             + 22'(dsum_q) - 22'(cda_pkg::BaseDays);
  end

  // stage 3: century terms, range check on the count
  logic signed [21:0] z_full;
  logic [15:0]        z_q;
  logic               err_d, err_q;

  always_comb begin
    z_full = part_q - $signed({16'b0, q_q}) + $signed({18'b0, q_q[5:2]});
    err_d  = (z_full < 22'(cda_pkg::CountMin)) || (z_full > 22'(cda_pkg::CountMax));
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      y_q    <= y_d;
      doy_q  <= doy_d;
      dsum_q <= dsum_d;
      p1_q   <= p1_d;
    end
    if (rdy2 && v1_q) begin
      q_q    <= q_d;
      part_q <= part_d;
    end
    if (rdy3 && v2_q) begin
      z_q    <= z_full[15:0];
      err_q  <= err_d;
    end
  end

  assign cnt_o.z   = z_q;
  assign cnt_o.err = err_q;

  // an in-range count fits the window of the backward half
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !err_q |-> z_q >= 16'(cda_pkg::CountMin) && z_q <= 16'(cda_pkg::CountMax))
    else $error("in-range day count outside window");

endmodule

>>> design/cda_from_count.sv
// Backward half: day count to date, four stages ending in the output register
module cda_from_count (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  ready_o,
  input  cda_pkg::count_t       cnt_i,
  output logic                  valid_o,
  input  logic                  ready_i,
  output logic [4:0]            result_day_o,
  output logic [3:0]            result_month_o,
  output logic [10:0]           result_year_o,
  output logic                  range_error_o
);

  // stage valid bits and ready chain
  logic v4_q, v5_q, v6_q, v7_q;
  logic rdy4, rdy5, rdy6, rdy7;

  assign rdy7    = !v7_q || ready_i;
  assign rdy6    = !v6_q || rdy7;
  assign rdy5    = !v5_q || rdy6;
  assign rdy4    = !v4_q || rdy5;
  assign ready_o = rdy4;
  assign valid_o = v7_q;

  // stage 4: reciprocal product for /1461
  logic [31:0] p2_d, p2_q;
  logic [15:0] z4_q;
  logic        e4_q;

  assign p2_d = 32'(cnt_i.z) * 32'(cda_pkg::Recip1461);

  // stage 5: four-year cycle index and day within the cycle
  logic [5:0]  k_est, k_d, k_q;
  logic [15:0] rr;
  logic [10:0] r_d, r_q;
  logic        e5_q;

  always_comb begin
    k_est = p2_q[31:26];
    rr    = z4_q - 16'(k_est) * 16'd1461;
    if (rr >= 16'd1461) begin
      k_d = k_est + 6'd1;
      r_d = 11'(rr - 16'd1461);
    end else begin
      k_d = k_est;
      r_d = rr[10:0];
    end
  end

  // stage 6: year within the cycle, day of the March-based year
  logic [1:0]  yoc;
  logic [7:0]  s_d, s_q;
  logic [8:0]  doy_d, doy_q;
  logic        e6_q;

  always_comb begin
    if (r_q >= 11'd1095)     yoc = 2'd3;
    else if (r_q >= 11'd730) yoc = 2'd2;
    else if (r_q >= 11'd365) yoc = 2'd1;
    else                     yoc = 2'd0;
    doy_d = 9'(r_q - 11'(yoc) * 11'd365);
    s_d   = {k_q, 2'b00} + 8'(yoc);
  end

  // stage 7: month search, day of month, calendar year
  logic [3:0]  mp, mm;
  logic [4:0]  dd;
  logic [10:0] ry;

  always_comb begin
    mp = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy_q >= cda_pkg::month_start(4'(i))) mp = 4'(i);
    end
    dd = 5'(doy_q - cda_pkg::month_start(mp) + 9'd1);
    mm = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    ry = 11'(cda_pkg::BaseYear) + {3'b000, s_q} + {10'b0, (mm <= 4'd2)};
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (rdy4) v4_q <= valid_i;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
      if (rdy7) v7_q <= v6_q;
    end
  end

  // payload registers, result zeroed on range error
  always_ff @(posedge clk_i) begin
    if (rdy4 && valid_i) begin
      p2_q  <= p2_d;
      z4_q  <= cnt_i.z;
      e4_q  <= cnt_i.err;
    end
    if (rdy5 && v4_q) begin
      k_q   <= k_d;
      r_q   <= r_d;
      e5_q  <= e4_q;
    end
    if (rdy6 && v5_q) begin
      s_q   <= s_d;
      doy_q <= doy_d;
      e6_q  <= e5_q;
    end
    if (rdy7 && v6_q) begin
      range_error_o  <= e6_q;
      result_day_o   <= e6_q ? 5'd0  : dd;
      result_month_o <= e6_q ? 4'd0  : mm;
      result_year_o  <= e6_q ? 11'd0 : ry;
    end
  end

  // remainder correction leaves a day inside one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && !e5_q |-> r_q < 11'd1461)
    else $error("cycle remainder out of range");

  // cycle index stays inside the supported window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && !e5_q |-> k_q <= 6'd34)
    else $error("cycle index out of range");

  // good results carry a real month and day
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q && !range_error_o |-> result_month_o >= 4'd1 && result_month_o <= 4'd12
                               && result_day_o >= 5'd1)
    else $error("bad month or day on good result");

  // good results carry a year in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v7_q && !range_error_o |-> result_year_o >= 11'd1902 && result_year_o <= 11'd2037)
    else $error("good result year out of range");

endmodule

>>> design/calendar_date_add_days.sv
// Channel   Direction  Handshake                 Payload
// req       in         req_valid_i / req_stall_o start_day, start_month, start_year,
//                                                day_offset
// rsp       out        rsp_valid_o / rsp_stall_i result_day, result_month, result_year,
//                                                range_error
//
// One request per cycle unless req_stall_o is high; each accepted request passes through 7
// register stages (3 form the day count, 4 split it back through a /1461 reciprocal, the
// last being the output register).
// Reset clears only the stage valid bits; payload registers are not reset.
// A stalled response holds; empty stages still fill, so requests keep flowing
// until every stage holds a request.
module calendar_date_add_days (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_stall_o,
  input  logic [4:0]          start_day_i,
  input  logic [3:0]          start_month_i,
  input  logic [10:0]         start_year_i,
  input  logic signed [16:0]  day_offset_i,
  output logic                rsp_valid_o,
  input  logic                rsp_stall_i,
  output logic [4:0]          result_day_o,
  output logic [3:0]          result_month_o,
  output logic [10:0]         result_year_o,
  output logic                range_error_o
);

  logic            fwd_ready;
  logic            cnt_valid;
  logic            cnt_ready;
  cda_pkg::count_t cnt;

  assign req_stall_o = !fwd_ready;

  // date to day count
  cda_to_count u_to_count (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (req_valid_i),
    .ready_o       (fwd_ready),
    .start_day_i   (start_day_i),
    .start_month_i (start_month_i),
    .start_year_i  (start_year_i),
    .day_offset_i  (day_offset_i),
    .valid_o       (cnt_valid),
    .ready_i       (cnt_ready),
    .cnt_o         (cnt)
  );

  // day count to date
  cda_from_count u_from_count (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (cnt_valid),
    .ready_o        (cnt_ready),
    .cnt_i          (cnt),
    .valid_o        (rsp_valid_o),
    .ready_i        (!rsp_stall_i),
    .result_day_o   (result_day_o),
    .result_month_o (result_month_o),
    .result_year_o  (result_year_o),
    .range_error_o  (range_error_o)
  );

endmodule

>>> tb/calendar_date_add_days_test.sv
`timescale 1ns / 100ps

module calendar_date_add_days_test;

  // Result fields as they appear on the response channel
  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [10:0] year;
    logic        range_error;
  } date_result_t;

  // One request, plus a result written out by hand where it is obvious
  typedef struct packed {
    logic [4:0]         day;
    logic [3:0]         month;
    logic [10:0]        year;
    logic signed [16:0] offset;
    logic               pinned;
    date_result_t       pinned_result;
  } date_request_t;

  localparam int YearLow     = 1902;
  localparam int YearHigh    = 2037;
  localparam int NumRandom   = 1250;
  localparam int NumDirected = 21;
  localparam int MaxWait     = 13;
  localparam int IdleLimit   = 400;
  localparam int DrainCycles = 24;
  localparam int ShowLimit   = 10;

  localparam date_result_t OutOfRange = '{day: 5'd0, month: 4'd0, year: 11'd0,
                                          range_error: 1'b1};
  localparam date_result_t NoPin = '0;

  // Directed rows: extremes of every field and the wrap cases of day and month
  localparam date_request_t DirectedRows [NumDirected] = '{
    '{5'd1,  4'd1,  11'd1902,  17'sd0,     1'b1, '{5'd1, 4'd1, 11'd1902, 1'b0}},
    '{5'd31, 4'd12, 11'd2037,  17'sd0,     1'b1, '{5'd31, 4'd12, 11'd2037, 1'b0}},
    '{5'd31, 4'd12, 11'd2037,  17'sd1,     1'b1, OutOfRange},
    '{5'd1,  4'd1,  11'd1902, -17'sd1,     1'b1, OutOfRange},
    '{5'd31, 4'd12, 11'd2037,  17'sd65535, 1'b1, OutOfRange},
    '{5'd1,  4'd1,  11'd1902, -17'sd65536, 1'b1, OutOfRange},
    '{5'd1,  4'd1,  11'd0,     17'sd0,     1'b1, OutOfRange},
    '{5'd1,  4'd1,  11'd1902,  17'sd65535, 1'b0, NoPin},
    '{5'd31, 4'd12, 11'd2037, -17'sd65536, 1'b0, NoPin},
    '{5'd0,  4'd3,  11'd2000,  17'sd0,     1'b0, NoPin},
    '{5'd0,  4'd3,  11'd1904,  17'sd0,     1'b0, NoPin},
    '{5'd31, 4'd4,  11'd2001,  17'sd0,     1'b0, NoPin},
    '{5'd31, 4'd2,  11'd2001,  17'sd0,     1'b0, NoPin},
    '{5'd15, 4'd0,  11'd2000,  17'sd0,     1'b0, NoPin},
    '{5'd15, 4'd13, 11'd2000,  17'sd0,     1'b0, NoPin},
    '{5'd15, 4'd14, 11'd2000,  17'sd0,     1'b0, NoPin},
    '{5'd15, 4'd15, 11'd2037,  17'sd0,     1'b0, NoPin},
    '{5'd31, 4'd15, 11'd2047, -17'sd65536, 1'b0, NoPin},
    '{5'd28, 4'd2,  11'd1999,  17'sd1,     1'b0, NoPin},
    '{5'd1,  4'd3,  11'd2000, -17'sd1,     1'b0, NoPin},
    '{5'd1,  4'd1,  11'd1901,  17'sd365,   1'b0, NoPin}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               req_valid_i = 1'b0;
  logic               req_stall_o;
  logic [4:0]         start_day_i = '0;
  logic [3:0]         start_month_i = '0;
  logic [10:0]        start_year_i = '0;
  logic signed [16:0] day_offset_i = '0;
  logic               rsp_valid_o;
  logic               rsp_stall_i = 1'b0;
  logic [4:0]         result_day_o;
  logic [3:0]         result_month_o;
  logic [10:0]        result_year_o;
  logic               range_error_o;

  date_request_t date_requests [$];
  date_result_t  pending_dates [$];
  int sent_count = 0;
  int recv_count = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int fail_count = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  calendar_date_add_days dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid_i),
    .req_stall_o    (req_stall_o),
    .start_day_i    (start_day_i),
    .start_month_i  (start_month_i),
    .start_year_i   (start_year_i),
    .day_offset_i   (day_offset_i),
    .rsp_valid_o    (rsp_valid_o),
    .rsp_stall_i    (rsp_stall_i),
    .result_day_o   (result_day_o),
    .result_month_o (result_month_o),
    .result_year_o  (result_year_o),
    .range_error_o  (range_error_o)
  );

  // Date plus offset through a day count; years biased by 2000 keep counts positive
  function automatic date_result_t shift_date(input logic [4:0] day, input logic [3:0] month,
                                              input logic [10:0] year,
                                              input logic signed [16:0] offset);
    longint mi, yb, yy, era, yoe, mp, doy, doe, z, ry, rm, rd;
    date_result_t r;
    mi = longint'(month) - 1;
    yb = longint'(year) + 2000;
    if (mi < 0) begin
      mi += 12;
      yb -= 1;
    end else if (mi >= 12) begin
      mi -= 12;
      yb += 1;
    end
    // forward: March-based year, so January and February belong to the year before
    yy  = (mi < 2) ? yb - 1 : yb;
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (mi >= 2) ? mi - 2 : mi + 10;
    doy = (153 * mp + 2) / 5;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    z   = era * 146097 + doe + longint'(day) - 1 + longint'(offset);
    // backward: split the count into era, year, month and day
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    rd  = doy - (153 * mp + 2) / 5 + 1;
    rm  = (mp < 10) ? mp + 3 : mp - 9;
    ry  = yoe + era * 400 + ((rm <= 2) ? 1 : 0) - 2000;
    if (ry < YearLow || ry > YearHigh) begin
      r = OutOfRange;
    end else begin
      r.day = rd[4:0];
      r.month = rm[3:0];
      r.year = ry[10:0];
      r.range_error = 1'b0;
    end
    return r;
  endfunction

  // Per-item wait; every third run of 40 items goes back to back
  function automatic int draw_gap(input int item_no);
    if ((item_no / 40) % 3 == 2) return 0;
    return $urandom_range(0, MaxWait);
  endfunction

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Request side: present a request, hold it while stalled, then wait
  always @(posedge clk_i) begin
    date_request_t r;
    if (rst_ni) begin
      if (req_valid_i && !req_stall_o) begin
        r = date_requests[sent_count];
        pending_dates.push_back(r.pinned ? r.pinned_result :
                                shift_date(r.day, r.month, r.year, r.offset));
        sent_count++;
        send_wait = draw_gap(sent_count);
      end
      if (req_valid_i && req_stall_o) begin
        // stalled: payload stays put
      end else if (send_wait > 0) begin
        send_wait--;
        req_valid_i <= 1'b0;
      end else if (sent_count < date_requests.size()) begin
        r = date_requests[sent_count];
        start_day_i   <= r.day;
        start_month_i <= r.month;
        start_year_i  <= r.year;
        day_offset_i  <= r.offset;
        req_valid_i   <= 1'b1;
      end else begin
        req_valid_i <= 1'b0;
      end
    end
  end

  // Response side: compare against the oldest pending date, then stall a while
  always @(posedge clk_i) begin
    date_result_t want, got;
    if (rst_ni) begin
      if (rsp_valid_o && !rsp_stall_i) begin
        got = '{day: result_day_o, month: result_month_o, year: result_year_o,
                range_error: range_error_o};
        if (pending_dates.size() == 0) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= ShowLimit)
            $display("unexpected response %0d/%0d/%0d err=%0b", got.day, got.month,
                     got.year, got.range_error);
        end else begin
          want = pending_dates.pop_front();
          if (got !== want) begin
            fail_count++;
            mismatch_count++;
            if (mismatch_count <= ShowLimit)
              $display("response %0d: expected %0d/%0d/%0d err=%0b, got %0d/%0d/%0d err=%0b",
                       recv_count, want.day, want.month, want.year, want.range_error,
                       got.day, got.month, got.year, got.range_error);
          end
        end
        recv_count++;
        recv_wait = draw_gap(recv_count);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        rsp_stall_i <= 1'b1;
      end else begin
        rsp_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_valid_i && !req_stall_o) || (rsp_valid_o && !rsp_stall_i))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    date_request_t r;
    int sel;
    for (int i = 0; i < NumDirected; i++) date_requests.push_back(DirectedRows[i]);
    for (int i = 0; i < NumRandom; i++) begin
      r = '0;
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        // well-formed date inside the supported years
        r.month = 4'($urandom_range(1, 12));
        r.day = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(29, 31))
                                            : 5'($urandom_range(1, 28));
        r.year = 11'($urandom_range(YearLow, YearHigh));
        case ($urandom_range(0, 2))
          0:       r.offset = 17'($signed($urandom_range(0, 800)) - 400);
          1:       r.offset = 17'($signed($urandom_range(0, 40000)) - 20000);
          default: r.offset = 17'($urandom);
        endcase
      end else begin
        // raw bits: day and month wrap, year may fall outside the range
        r.day = 5'($urandom);
        r.month = 4'($urandom);
        r.year = 11'($urandom);
        r.offset = 17'($urandom);
      end
      date_requests.push_back(r);
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (sent_count < date_requests.size() || pending_dates.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
